// ----- src/ccd_pkg.sv -----
// Shared types, constants and constant tables for the contrast driven colour darkener.
package ccd_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_BG_RED        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_GREEN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_BLUE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATIO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DARKEN_ENABLE = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RST_BG_RED        = 8'd253;
  localparam logic [7:0]  RST_BG_GREEN      = 8'd253;
  localparam logic [7:0]  RST_BG_BLUE       = 8'd254;
  localparam logic [12:0] RST_TARGET_RATIO  = 13'd1152;
  localparam logic        RST_DARKEN_ENABLE = 1'b1;

  // Datapath widths.
  localparam int LIN_W    = 17;  // linearised channel, Q0.16 up to 1.0
  localparam int WEIGHT_W = 16;  // luminance weights, Q0.16
  localparam int LUMA_W   = 33;  // luminance, Q0.32 up to 1.0
  localparam int HIK_W    = 34;  // brighter luminance plus offset
  localparam int PROD_W   = LUMA_W + WEIGHT_W;

  // Luminance weights, Q0.16, summing to 1.0.
  localparam logic [WEIGHT_W-1:0] W_RED   = 16'd13933;
  localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd46871;
  localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd4732;

  // The 0.05 offset of the contrast formula, Q0.32.
  localparam logic [LUMA_W-1:0] OFFSET_Q32 = 33'd214748365;

  // Constants used only while the tables are built at elaboration.
  localparam logic [63:0] LIN_DEN_SMALL = 64'd65892;
  localparam logic [63:0] LIN_DEN_GAMMA = 64'd269025;
  localparam logic [63:0] ONE_Q30       = 64'd1 << 30;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [4:0] steps_taken;
    logic       readable;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BG_LUMA,
    ST_FG_LUMA,
    ST_RATIO,
    ST_RMUL,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  typedef logic [255:0][LIN_W-1:0] lin_tab_t;
  typedef logic [255:0][7:0]       dark_tab_t;

  // sRGB to linear conversion. The linear segment is a rounded division; above it the
  // power 2.4 is formed as t^2 times (t^2)^(1/5), with the fifth root found by a
  // bisection over Q2.30 values whose truncated fifth power does not exceed the square.
  function automatic lin_tab_t build_lin_tab();
    lin_tab_t    tab;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] r2;
    logic [63:0] r4;
    logic [63:0] p5;
    logic [63:0] y;
    for (int v = 0; v < 256; v++) begin
      if (v <= 10) begin
        tab[v] = LIN_W'((64'(v) * 64'd1310720 + 64'd32946) / LIN_DEN_SMALL);
      end else begin
        t  = (64'(1000 * v + 14025) << 30) / LIN_DEN_GAMMA;
        s  = (t * t) >> 30;
        lo = 64'd0;
        hi = ONE_Q30;
        for (int k = 0; k < 40; k++) begin
          if (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            r2  = (mid * mid) >> 30;
            r4  = (r2 * r2) >> 30;
            p5  = (r4 * mid) >> 30;
            if (p5 <= s) begin
              lo = mid;
            end else begin
              hi = mid - 64'd1;
            end
          end
        end
        y      = (s * lo) >> 30;
        tab[v] = LIN_W'((y + 64'd8192) >> 14);
      end
    end
    return tab;
  endfunction

  // One darkening step on a channel: floor(c * 92 / 100).
  function automatic dark_tab_t build_dark_tab();
    dark_tab_t tab;
    for (int c = 0; c < 256; c++) begin
      tab[c] = 8'((c * 92) / 100);
    end
    return tab;
  endfunction

  localparam lin_tab_t  LIN_TAB  = build_lin_tab();
  localparam dark_tab_t DARK_TAB = build_dark_tab();

endpackage

// ----- src/contrast_driven_color_darkener_top.sv -----
// Top level of the contrast driven colour darkener: sequencer, shared multiplier and config.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    in_data   (ccd_pkg::in_word_t)
//   out_      output     out_valid / out_ready  out_data  (ccd_pkg::out_word_t)
//   cfg_      input      cfg_we                 cfg_index, cfg_wdata
//
// After acceptance a word runs the background and colour luminance passes, then the ratio,
// ratio product and decide states, returning to the colour pass for each darkening step;
// the finish state then loads the result. The single multiplier serves every luminance term
// and the ratio product, one product per cycle with a register behind it.
// Reset is synchronous and active low; it restores the background, target and enable
// registers to their documented values and empties the result register.
// in_ready is high only while the sequencer is idle. A finished result sits in the output
// register, so a new word may be accepted before it is taken; the next result then waits
// until the output register is free.
module contrast_driven_color_darkener_top #(
  parameter int MAX_STEPS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ccd_pkg::in_word_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ccd_pkg::out_word_t                 out_data,
  input  logic                               cfg_we,
  input  logic [ccd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ccd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // The step counter must hold MAX_STEPS itself.
  localparam int STEP_W = $clog2(MAX_STEPS + 1);

  // Configuration registers.
  logic [7:0]  bg_red_r;
  logic [7:0]  bg_green_r;
  logic [7:0]  bg_blue_r;
  logic [12:0] target_r;
  logic        enable_r;

  // Sequencer state.
  ccd_pkg::state_t state_r, state_nxt;
  logic [1:0]      term_r;
  logic [STEP_W-1:0] steps_r;

  // Datapath registers.
  ccd_pkg::in_word_t                col_r;
  logic [ccd_pkg::LUMA_W-1:0]       acc_r;
  logic [ccd_pkg::LUMA_W-1:0]       bg_lum_r;
  logic [ccd_pkg::LUMA_W-1:0]       fg_lum_r;
  logic [ccd_pkg::HIK_W-1:0]        hik_r;
  logic [ccd_pkg::LUMA_W-1:0]       lok_r;
  logic [ccd_pkg::PROD_W-1:0]       prod_r;
  logic                             readable_r;
  ccd_pkg::out_word_t               out_r;
  logic                             out_valid_r;

  // Combinational signals.
  logic [7:0]                       fg_ch;
  logic [7:0]                       bg_ch;
  logic [7:0]                       mul_ch;
  logic [ccd_pkg::WEIGHT_W-1:0]     weight;
  logic [ccd_pkg::LIN_W-1:0]        lin_val;
  logic [ccd_pkg::LUMA_W-1:0]       mul_a;
  logic [ccd_pkg::WEIGHT_W-1:0]     mul_b;
  logic [ccd_pkg::PROD_W-1:0]       mul_p;
  logic [ccd_pkg::LUMA_W-1:0]       lum_sum;
  logic                             fg_brighter;
  logic [ccd_pkg::LUMA_W-1:0]       lum_hi;
  logic [ccd_pkg::LUMA_W-1:0]       lum_lo;
  logic                             below;
  logic                             can_step;
  logic                             luma_active;
  logic                             do_darken;
  logic                             load_out;
  logic                             in_fire;

  assign in_fire = in_valid && in_ready;

  // Select the channel and weight for the current luminance term. The background is
  // taken from the configuration registers, the colour from the working copy.
  always_comb begin
    case (term_r)
      2'd0: begin
        fg_ch  = col_r.red_in;
        bg_ch  = bg_red_r;
        weight = ccd_pkg::W_RED;
      end
      2'd1: begin
        fg_ch  = col_r.green_in;
        bg_ch  = bg_green_r;
        weight = ccd_pkg::W_GREEN;
      end
      default: begin
        fg_ch  = col_r.blue_in;
        bg_ch  = bg_blue_r;
        weight = ccd_pkg::W_BLUE;
      end
    endcase
  end

  assign mul_ch  = (state_r == ccd_pkg::ST_BG_LUMA) ? bg_ch : fg_ch;
  assign lin_val = ccd_pkg::LIN_TAB[mul_ch];

  // The one shared multiplier: weight times linear channel during the luminance passes,
  // target ratio times (darker luminance + offset) for the ratio test.
  assign mul_a = (state_r == ccd_pkg::ST_RMUL) ? lok_r : ccd_pkg::LUMA_W'(lin_val);
  assign mul_b = (state_r == ccd_pkg::ST_RMUL) ? ccd_pkg::WEIGHT_W'(target_r) : weight;
  assign mul_p = ccd_pkg::PROD_W'(mul_a) * ccd_pkg::PROD_W'(mul_b);

  // Each luminance term is below 2^32, so the low product bits carry it whole.
  assign lum_sum = acc_r + prod_r[ccd_pkg::LUMA_W-1:0];

  assign fg_brighter = fg_lum_r > bg_lum_r;
  assign lum_hi      = fg_brighter ? fg_lum_r : bg_lum_r;
  assign lum_lo      = fg_brighter ? bg_lum_r : fg_lum_r;

  // Contrast is short of the target when (hi + K) * 256 < target * (lo + K).
  assign below    = ccd_pkg::PROD_W'({hik_r, 8'd0}) < prod_r;
  assign can_step = enable_r && (steps_r < STEP_W'(MAX_STEPS));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ccd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ccd_pkg::ST_BG_LUMA;
        end
      end
      ccd_pkg::ST_BG_LUMA: begin
        if (term_r == 2'd3) begin
          state_nxt = ccd_pkg::ST_FG_LUMA;
        end
      end
      ccd_pkg::ST_FG_LUMA: begin
        if (term_r == 2'd3) begin
          state_nxt = ccd_pkg::ST_RATIO;
        end
      end
      ccd_pkg::ST_RATIO: begin
        state_nxt = ccd_pkg::ST_RMUL;
      end
      ccd_pkg::ST_RMUL: begin
        state_nxt = ccd_pkg::ST_DECIDE;
      end
      ccd_pkg::ST_DECIDE: begin
        if (below && can_step) begin
          state_nxt = ccd_pkg::ST_FG_LUMA;
        end else begin
          state_nxt = ccd_pkg::ST_FINISH;
        end
      end
      ccd_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ccd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ccd_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready    = 1'b0;
    luma_active = 1'b0;
    do_darken   = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      ccd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      ccd_pkg::ST_BG_LUMA, ccd_pkg::ST_FG_LUMA: begin
        luma_active = 1'b1;
      end
      ccd_pkg::ST_DECIDE: begin
        do_darken = below && can_step;
      end
      ccd_pkg::ST_FINISH: begin
        load_out = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ccd_pkg::ST_IDLE;
      term_r      <= 2'd0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
      bg_red_r    <= ccd_pkg::RST_BG_RED;
      bg_green_r  <= ccd_pkg::RST_BG_GREEN;
      bg_blue_r   <= ccd_pkg::RST_BG_BLUE;
      target_r    <= ccd_pkg::RST_TARGET_RATIO;
      enable_r    <= ccd_pkg::RST_DARKEN_ENABLE;
    end else begin
      state_r <= state_nxt;

      // The term counter steps through terms 0..3 in each luminance pass and wraps to zero.
      if (luma_active) begin
        term_r <= term_r + 2'd1;
      end

      if (in_fire) begin
        steps_r <= '0;
      end else if (do_darken) begin
        steps_r <= steps_r + STEP_W'(1);
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          ccd_pkg::CFG_BG_RED:        bg_red_r   <= cfg_wdata[7:0];
          ccd_pkg::CFG_BG_GREEN:      bg_green_r <= cfg_wdata[7:0];
          ccd_pkg::CFG_BG_BLUE:       bg_blue_r  <= cfg_wdata[7:0];
          ccd_pkg::CFG_TARGET_RATIO:  target_r   <= cfg_wdata[12:0];
          ccd_pkg::CFG_DARKEN_ENABLE: enable_r   <= cfg_wdata[0];
          default: begin
            // Writes to unused indexes are dropped.
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      col_r <= in_data;
    end

    // Luminance pass: the product for each of terms 0..2 is registered in prod_r and summed
    // on the following term, so the pass closes at term 3 with the last product.
    if (luma_active) begin
      prod_r <= mul_p;
      case (term_r)
        2'd0: begin
          acc_r <= '0;
        end
        2'd3: begin
          if (state_r == ccd_pkg::ST_BG_LUMA) begin
            bg_lum_r <= lum_sum;
          end else begin
            fg_lum_r <= lum_sum;
          end
        end
        default: begin
          acc_r <= lum_sum;
        end
      endcase
    end

    if (state_r == ccd_pkg::ST_RATIO) begin
      hik_r <= ccd_pkg::HIK_W'(lum_hi) + ccd_pkg::HIK_W'(ccd_pkg::OFFSET_Q32);
      lok_r <= lum_lo + ccd_pkg::OFFSET_Q32;
    end

    if (state_r == ccd_pkg::ST_RMUL) begin
      prod_r <= mul_p;
    end

    if (state_r == ccd_pkg::ST_DECIDE) begin
      readable_r <= !below;
      if (do_darken) begin
        col_r.red_in   <= ccd_pkg::DARK_TAB[col_r.red_in];
        col_r.green_in <= ccd_pkg::DARK_TAB[col_r.green_in];
        col_r.blue_in  <= ccd_pkg::DARK_TAB[col_r.blue_in];
      end
    end

    if (load_out) begin
      out_r.red_out     <= col_r.red_in;
      out_r.green_out   <= col_r.green_in;
      out_r.blue_out    <= col_r.blue_in;
      out_r.steps_taken <= (32'(steps_r) > 32'd31) ? 5'd31 : 5'(steps_r);
      out_r.readable    <= readable_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The step count never passes its limit.
  a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= STEP_W'(MAX_STEPS))
    else $error("step counter beyond its limit");

  // A result leaves only when the target is met, the step limit is reached or
  // darkening is off.
  a_stop_reason: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (readable_r || steps_r == STEP_W'(MAX_STEPS) || !enable_r))
    else $error("darkening stopped early");

  // With darkening off no step is reported.
  a_disabled_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && !enable_r) |=> (out_r.steps_taken == 5'd0))
    else $error("steps reported while darkening is off");

  // A darkening step never makes a channel brighter.
  a_darken_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    do_darken |=> (col_r.red_in <= $past(col_r.red_in) &&
                   col_r.green_in <= $past(col_r.green_in) &&
                   col_r.blue_in <= $past(col_r.blue_in)))
    else $error("darkening raised a channel");

endmodule
